/* design/u8re_pkg.sv */
package u8re_pkg;

  localparam int HoldMax      = 6;
  localparam int QueueDepth   = 4;
  localparam int CodeW        = 16;

  localparam logic [7:0] ChU    = 8'h55;
  localparam logic [7:0] ChPlus = 8'h2b;

  typedef enum logic [0:0] {
    FR_IDLE,
    FR_RESOLVE
  } fr_state_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             raw;
    logic             last;
  } req_t;

endpackage

/* design/u8re_fifo.sv */
module u8re_fifo #(
  parameter int DEPTH = u8re_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u8re_pkg::req_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output u8re_pkg::req_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8re_pkg::req_t mem_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

/* design/u8re_front.sv */
module u8re_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  output logic           push,
  output u8re_pkg::req_t push_data,
  input  logic           q_full
);

  localparam int HM = u8re_pkg::HoldMax;

  u8re_pkg::fr_state_t state_r, state_nxt;
  logic [7:0]  buf_r [HM];
  logic [7:0]  buf_nxt [HM];
  logic [2:0]  cnt_r, cnt_nxt;
  logic        held_v_r, held_v_nxt;
  logic [15:0] held_code_r, held_code_nxt;
  logic        held_raw_r, held_raw_nxt;

  logic [2:0]  rk;
  logic [15:0] rcode;
  logic        rraw;
  logic [7:0]  b0, b1, b2, b3, b4, b5;
  logic [10:0] outer, v0, v1;
  logic [3:0]  sel;

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  assign b0 = buf_r[0];
  assign b1 = buf_r[1];
  assign b2 = buf_r[2];
  assign b3 = buf_r[3];
  assign b4 = buf_r[4];
  assign b5 = buf_r[5];
  assign outer = {b0[4:0], b1[5:0]};
  assign v0    = {b2[4:0], b3[5:0]};
  assign v1    = {b4[4:0], b5[5:0]};

  // one resolve step over the held bytes
  always_comb begin
    rk    = 3'd0;
    rcode = {8'h00, b0};
    rraw  = 1'b0;
    if (cnt_r == 3'd0) begin
      rk = 3'd0;
    end else if (b0 < 8'h80) begin
      rk   = 3'd1;
      rraw = 1'b1;
    end else if (b0 < 8'hc2 || b0 >= 8'hf0) begin
      rk = 3'd1;
    end else if (cnt_r < 3'd2) begin
      rk = 3'd0;
    end else if (!is_cont(b1)) begin
      rk = 3'd1;
    end else if (b0 >= 8'he0) begin
      if (cnt_r < 3'd3) begin
        rk = 3'd0;
      end else if (!is_cont(b2)) begin
        rk = 3'd1;
      end else begin
        rk    = 3'd3;
        rcode = {b0[3:0], b1[5:0], b2[5:0]};
      end
    end else begin
      rcode = {5'd0, outer};
      if (outer < 11'h0c2 || outer > 11'h0ef) begin
        rk = 3'd2;
      end else if (cnt_r <= 3'd2) begin
        rk = 3'd0;
      end else if (b2 != 8'hc2 && b2 != 8'hc3) begin
        rk = 3'd2;
      end else if (cnt_r <= 3'd3) begin
        rk = 3'd0;
      end else if (!is_cont(b3) || v0 >= 11'h0c0) begin
        rk = 3'd2;
      end else if (outer < 11'h0e0) begin
        rk    = 3'd4;
        rcode = {5'd0, outer[4:0], v0[5:0]};
      end else if (cnt_r <= 3'd4) begin
        rk = 3'd0;
      end else if (b4 != 8'hc2 && b4 != 8'hc3) begin
        rk = 3'd2;
      end else if (cnt_r <= 3'd5) begin
        rk = 3'd0;
      end else if (!is_cont(b5) || v1 >= 11'h0c0) begin
        rk = 3'd2;
      end else begin
        rk    = 3'd6;
        rcode = {outer[3:0], v0[5:0], v1[5:0]};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      u8re_pkg::FR_IDLE: begin
        if (in_valid) state_nxt = u8re_pkg::FR_RESOLVE;
      end
      u8re_pkg::FR_RESOLVE: begin
        if (rk == 3'd0 && !(held_v_r && q_full)) state_nxt = u8re_pkg::FR_IDLE;
      end
      default: state_nxt = u8re_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != u8re_pkg::FR_IDLE);
    push           = 1'b0;
    push_data.code = held_code_r;
    push_data.raw  = held_raw_r;
    push_data.last = 1'b0;
    cnt_nxt        = cnt_r;
    held_v_nxt     = held_v_r;
    held_code_nxt  = held_code_r;
    held_raw_nxt   = held_raw_r;
    sel            = '0;
    for (int i = 0; i < HM; i++) buf_nxt[i] = buf_r[i];
    case (state_r)
      u8re_pkg::FR_IDLE: begin
        if (in_valid) begin
          buf_nxt[cnt_r] = in_byte;
          cnt_nxt        = cnt_r + 3'd1;
        end
      end
      u8re_pkg::FR_RESOLVE: begin
        if (!(held_v_r && q_full)) begin
          if (rk != 3'd0) begin
            push          = held_v_r;
            held_v_nxt    = 1'b1;
            held_code_nxt = rcode;
            held_raw_nxt  = rraw;
            cnt_nxt       = cnt_r - rk;
            for (int i = 0; i < HM; i++) begin
              sel = 4'(i) + {1'b0, rk};
              if (sel < 4'(HM)) buf_nxt[i] = buf_r[sel[2:0]];
            end
          end else begin
            push           = held_v_r;
            push_data.last = 1'b1;
            held_v_nxt     = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= u8re_pkg::FR_IDLE;
      cnt_r    <= '0;
      held_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      held_v_r <= held_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_code_r <= held_code_nxt;
    held_raw_r  <= held_raw_nxt;
    for (int i = 0; i < HM; i++) buf_r[i] <= buf_nxt[i];
  end

endmodule

/* design/u8re_back.sv */
module u8re_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data,
  input  logic           q_empty,
  output logic           pop,
  input  u8re_pkg::req_t pop_data,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last_of_run
);

  logic           mode_r;
  logic           busy_r, busy_nxt;
  u8re_pkg::req_t ent_r;
  logic [2:0]     idx_r, idx_nxt, nb, j;
  logic           ov_r, ov_nxt;
  logic [7:0]     ob_r, ob_nxt, cur;
  logic           ol_r, ol_nxt;
  logic           adv, wide;
  logic [15:0]    c;

  function automatic logic [7:0] hexd(input logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction

  assign c    = ent_r.code;
  assign wide = (c > 16'h00ff);
  assign adv  = !ov_r || !out_stall;
  assign pop  = !busy_r && !q_empty;

  always_comb begin
    j   = (wide || idx_r < 3'd2) ? idx_r : idx_r + 3'd2;
    nb  = 3'd1;
    cur = c[7:0];
    if (ent_r.raw) begin
      nb  = 3'd1;
      cur = c[7:0];
    end else if (mode_r) begin
      nb = wide ? 3'd7 : 3'd5;
      case (j)
        3'd0:    cur = u8re_pkg::ChU;
        3'd1:    cur = u8re_pkg::ChPlus;
        3'd2:    cur = hexd(c[15:12]);
        3'd3:    cur = hexd(c[11:8]);
        3'd4:    cur = hexd(c[7:4]);
        3'd5:    cur = hexd(c[3:0]);
        default: cur = u8re_pkg::ChU;
      endcase
    end else if (c < 16'h0080) begin
      nb  = 3'd1;
      cur = c[7:0];
    end else if (c < 16'h0800) begin
      nb  = 3'd2;
      cur = (idx_r == 3'd0) ? {3'b110, c[10:6]} : {2'b10, c[5:0]};
    end else begin
      nb = 3'd3;
      case (idx_r)
        3'd0:    cur = {4'b1110, c[15:12]};
        3'd1:    cur = {2'b10, c[11:6]};
        default: cur = {2'b10, c[5:0]};
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    if (adv) ov_nxt = 1'b0;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r && adv) begin
      ov_nxt  = 1'b1;
      ob_nxt  = cur;
      ol_nxt  = ent_r.last && (idx_r == nb - 3'd1);
      idx_nxt = idx_r + 3'd1;
      if (idx_r == nb - 3'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
    if (pop) ent_r <= pop_data;
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_last_of_run = ol_r;

endmodule

/* design/utf8_repair_and_escape.sv */
// UTF-8 repair and escape transcoder.
// Input channel: in_valid/in_stall/in_byte, one raw stream byte per request.
// Output channel: out_valid/out_stall/out_byte/out_last_of_run; the last byte
// caused by an input byte carries out_last_of_run.
// cfg_wr_en/cfg_wr_data sets output_mode (0 UTF-8, 1 U+hex escape); write
// only while idle.
// The front takes a byte, then resolves one code point per cycle from its
// six-byte hold buffer while the queue is not full; in_stall stays high
// until no further code resolves, and only then is the next byte taken.
// Codes pass through a QUEUE_DEPTH queue to the back, which loads each code
// into its entry register and then emits one byte per cycle while out_stall
// is low (1 to 7 bytes per code), popping the next code after the last byte.
// Reset (synchronous, rst_n low) empties the hold buffer and queue and sets
// output_mode to 0. When out_stall is high while out_valid is set, the
// output register holds; the queue then fills and the front raises in_stall.
module utf8_repair_and_escape #(
  parameter int QUEUE_DEPTH = u8re_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic           push, q_full, pop, q_empty;
  u8re_pkg::req_t push_data, pop_data;

  u8re_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  u8re_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  u8re_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .q_empty         (q_empty),
    .pop             (pop),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* design/u8re_checker.sv */
module u8re_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_of_run
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not quiet after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken without resolve phase");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("stalled output changed");

endmodule

bind utf8_repair_and_escape u8re_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);
